// File: design/dkdc_pkg.sv
// Shared types and constants of the dual Kalman differential current block.
package dkdc_pkg;

  localparam int unsigned CFG_W    = 32;
  localparam int unsigned NOISE_W  = 32;
  localparam int unsigned COV_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned APC_FRAC = 24;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE = 3'd0;
  localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 3'd1;
  localparam logic [IDX_W-1:0] REG_NUM_SAMPLES   = 3'd2;
  localparam logic [IDX_W-1:0] REG_AMPS_PER_CNT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_CUR_OFFSET    = 3'd4;
  localparam logic [IDX_W-1:0] REG_INIT_COV_SNS  = 3'd5;
  localparam logic [IDX_W-1:0] REG_INIT_COV_REF  = 3'd6;

  typedef struct packed {
    logic [NOISE_W-1:0] q;
    logic [NOISE_W-1:0] r;
  } dkdc_noise_t;

  typedef struct packed {
    logic [CNT_W-1:0]        target;
    logic [CFG_W-1:0]        apc;
    logic signed [CFG_W-1:0] offset;
  } dkdc_scale_t;

endpackage

// File: design/dkdc_lane.sv
// One scalar Kalman filter lane with a bit-serial gain divider.
module dkdc_lane
  import dkdc_pkg::*;
#(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ADC_BITS-1:0]           z_i,
  input  dkdc_noise_t                   noise_i,
  input  logic                          load_i,
  input  logic [CNT_W-1:0]              init_i,
  output logic                          done_o,
  output logic [ADC_BITS+FRAC_BITS-1:0] est_o
);

  localparam int unsigned EST_W = ADC_BITS + FRAC_BITS;
  localparam int unsigned K_W   = FRAC_BITS + 1;
  localparam int unsigned DEN_W = COV_W + 1;
  localparam int unsigned STP_W = $clog2(K_W + 1);
  localparam logic [K_W-1:0] ONE = K_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {L_IDLE, L_DIV, L_MUL, L_UPD} lane_state_e;

  lane_state_e             state_q;
  logic [EST_W-1:0]        est_q;
  logic [COV_W-1:0]        cov_q, pp_q;
  logic [DEN_W-1:0]        den_q, rem_q;
  logic                    nb_q, dz_q, up_q, done_q;
  logic [K_W-1:0]          k_q;
  logic [STP_W-1:0]        step_q;
  logic [ADC_BITS-1:0]     z_q;
  logic [K_W+EST_W-1:0]    px_q;
  logic [K_W+COV_W-1:0]    pc_q;

  logic [COV_W:0]          pp_sum;
  logic [COV_W-1:0]        pp_d;
  logic [DEN_W-1:0]        den_d;
  logic [DEN_W:0]          trial;
  logic [63:0]             init_wide;
  logic [COV_W-1:0]        init_cov;
  logic [EST_W-1:0]        zf, mag;
  logic [K_W-1:0]          k_eff;

  always_comb begin
    pp_sum    = {1'b0, cov_q} + {1'b0, noise_i.q};
    pp_d      = pp_sum[COV_W] ? '1 : pp_sum[COV_W-1:0];
    den_d     = {1'b0, pp_d} + {1'b0, noise_i.r};
    trial     = {rem_q, nb_q};
    init_wide = 64'(init_i) << FRAC_BITS;
    init_cov  = (|init_wide[63:COV_W]) ? '1 : init_wide[COV_W-1:0];
    zf        = {z_q, {FRAC_BITS{1'b0}}};
    mag       = (zf >= est_q) ? zf - est_q : est_q - zf;
    k_eff     = dz_q ? '0 : k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      est_q   <= '0;
      cov_q   <= '0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (load_i) begin
            cov_q <= init_cov;
          end else if (start_i) begin
            z_q     <= z_i;
            pp_q    <= pp_d;
            den_q   <= den_d;
            dz_q    <= (den_d == '0);
            rem_q   <= DEN_W'(pp_d >> 1);
            nb_q    <= pp_d[0];
            k_q     <= '0;
            step_q  <= '0;
            state_q <= L_DIV;
          end
        end
        L_DIV: begin
          // Restoring division: one quotient bit of the gain per cycle.
          if (trial >= {1'b0, den_q}) begin
            rem_q <= DEN_W'(trial - {1'b0, den_q});
            k_q   <= {k_q[K_W-2:0], 1'b1};
          end else begin
            rem_q <= trial[DEN_W-1:0];
            k_q   <= {k_q[K_W-2:0], 1'b0};
          end
          nb_q   <= 1'b0;
          step_q <= step_q + 1'b1;
          if (step_q == STP_W'(K_W - 1)) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          up_q    <= (zf >= est_q);
          px_q    <= k_eff * mag;
          pc_q    <= (ONE - k_eff) * pp_q;
          state_q <= L_UPD;
        end
        L_UPD: begin
          if (up_q) begin
            est_q <= est_q + px_q[FRAC_BITS +: EST_W];
          end else begin
            est_q <= est_q - px_q[FRAC_BITS +: EST_W];
          end
          cov_q   <= pc_q[FRAC_BITS +: COV_W];
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign est_o  = est_q;

endmodule

// File: design/dkdc_merge.sv
// Merging stage: difference sum, serial mean divider, scaling and output register.
module dkdc_merge
  import dkdc_pkg::*;
#(
  parameter int unsigned EST_W = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    add_i,
  input  logic [EST_W-1:0]        est_a_i,
  input  logic [EST_W-1:0]        est_b_i,
  input  dkdc_scale_t             scale_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [CFG_W-1:0] dc_current_o,
  output logic [EST_W-1:0]        mean_difference_o
);

  localparam int unsigned SUM_W = EST_W + CNT_W;
  localparam int unsigned STP_W = $clog2(EST_W + 1);
  localparam int unsigned PRD_W = EST_W + CFG_W;
  localparam int unsigned SCL_W = PRD_W - APC_FRAC;
  localparam int unsigned DC_W  = SCL_W + 2;

  typedef enum logic [2:0] {M_IDLE, M_DIV, M_MUL, M_SAT, M_HOLD} merge_state_e;

  merge_state_e            state_q;
  logic [SUM_W-1:0]        sum_q;
  logic [CNT_W-1:0]        cnt_q, div_q;
  logic [CNT_W-1:0]        rem_q;
  logic [EST_W-1:0]        num_q;
  logic [STP_W-1:0]        step_q;
  logic [PRD_W-1:0]        prod_q;
  logic signed [CFG_W-1:0] dc_q, dc_out_q;
  logic [EST_W-1:0]        mean_out_q;
  logic                    out_valid_q;

  logic [EST_W-1:0]        diff;
  logic [SUM_W-1:0]        sum_new;
  logic [CNT_W-1:0]        cnt_new, target;
  logic                    emit;
  logic                    load_out;
  logic [CNT_W:0]          trial;
  logic signed [DC_W-1:0]  dc_wide;
  logic signed [CFG_W-1:0] dc_sat;

  always_comb begin
    diff     = (est_a_i >= est_b_i) ? est_a_i - est_b_i : est_b_i - est_a_i;
    sum_new  = sum_q + SUM_W'(diff);
    cnt_new  = cnt_q + 1'b1;
    target   = (scale_i.target == '0) ? CNT_W'(1) : scale_i.target;
    emit     = (cnt_new != '0) && (cnt_new >= target);
    load_out = (state_q == M_HOLD) && (!out_valid_q || out_ready_i);
    trial    = {rem_q, num_q[EST_W-1]};
    dc_wide  = $signed({2'b00, prod_q[PRD_W-1:APC_FRAC]})
             - $signed({{(DC_W-CFG_W){scale_i.offset[CFG_W-1]}}, scale_i.offset});
    if (!dc_wide[DC_W-1] && (|dc_wide[DC_W-2:CFG_W-1])) begin
      dc_sat = {1'b0, {(CFG_W-1){1'b1}}};
    end else if (dc_wide[DC_W-1] && !(&dc_wide[DC_W-2:CFG_W-1])) begin
      dc_sat = {1'b1, {(CFG_W-1){1'b0}}};
    end else begin
      dc_sat = dc_wide[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= M_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        M_IDLE: begin
          if (add_i) begin
            if (emit) begin
              div_q   <= cnt_new;
              num_q   <= sum_new[EST_W-1:0];
              rem_q   <= sum_new[SUM_W-1:EST_W];
              step_q  <= '0;
              sum_q   <= '0;
              cnt_q   <= '0;
              state_q <= M_DIV;
            end else begin
              sum_q <= sum_new;
              cnt_q <= cnt_new;
            end
          end
        end
        M_DIV: begin
          // Quotient bits shift into the dividend register as it empties.
          if (trial >= {1'b0, div_q}) begin
            rem_q <= CNT_W'(trial - {1'b0, div_q});
            num_q <= {num_q[EST_W-2:0], 1'b1};
          end else begin
            rem_q <= trial[CNT_W-1:0];
            num_q <= {num_q[EST_W-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == STP_W'(EST_W - 1)) begin
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          prod_q  <= PRD_W'(num_q) * PRD_W'(scale_i.apc);
          state_q <= M_SAT;
        end
        M_SAT: begin
          dc_q    <= dc_sat;
          state_q <= M_HOLD;
        end
        M_HOLD: begin
          if (load_out) begin
            dc_out_q   <= dc_q;
            mean_out_q <= num_q;
            state_q    <= M_IDLE;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign ready_o           = (state_q == M_IDLE);
  assign out_valid_o       = out_valid_q;
  assign dc_current_o      = dc_out_q;
  assign mean_difference_o = mean_out_q;

endmodule

// File: design/dual_kalman_differential_current.sv
// Top level of the dual Kalman differential current meter.
//
// Usage: each input word on the in channel (valid/ready) is one pair of ADC
// samples, sensor and reference. Each sample runs through its own scalar
// Kalman lane; the two lanes work side by side, each with a bit-serial
// divider that forms the gain one bit per cycle. The merge stage sums the
// absolute difference of the two estimates. After num_samples pairs it
// divides the sum by the pair count (one bit per cycle), scales the mean
// to amperes, subtracts the offset and saturates, then presents one word
// on the out channel (valid/ready).
// Flow: a pair that closes no group passes each lane's gain divider, multiply
// and update steps. A pair that closes a group then also passes the mean
// divider, the scaling multiply and the saturation step. One word is in
// work at a time.
// Reset clears the estimates, the sum, the count and both covariances.
// A finished result sits in the output register; while the receiver
// stalls the block still accepts and filters the next pair, and the stall
// holds off new input only once a further result is ready and waiting.
// Configuration writes: the user must make them only while the block is
// idle; the block itself does not enforce this.
module dual_kalman_differential_current
  import dkdc_pkg::*;
#(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ADC_BITS-1:0]           sensor_sample_i,
  input  logic [ADC_BITS-1:0]           reference_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [CFG_W-1:0]       dc_current_o,
  output logic [ADC_BITS+FRAC_BITS-1:0] mean_difference_o,
  input  logic                          cfg_we_i,
  input  logic [IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int unsigned EST_W = ADC_BITS + FRAC_BITS;

  typedef enum logic {T_IDLE, T_BUSY} top_state_e;

  top_state_e         state_q;
  dkdc_noise_t        noise_q;
  dkdc_scale_t        scale_q;

  logic               accept, merge_ready, sns_done, ref_done;
  logic               load_sns, load_ref;
  logic [EST_W-1:0]   est_sns, est_ref;

  assign accept   = in_valid_i && in_ready_o;
  assign load_sns = cfg_we_i && (cfg_idx_i == REG_INIT_COV_SNS);
  assign load_ref = cfg_we_i && (cfg_idx_i == REG_INIT_COV_REF);

  // Configuration registers. The initial covariance writes go straight to
  // the lanes, which load their covariance from the write data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q.q       <= CFG_W'(65536);
      noise_q.r       <= CFG_W'(65536);
      scale_q.target  <= CNT_W'(16);
      scale_q.apc     <= '0;
      scale_q.offset  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROCESS_NOISE: noise_q.q      <= cfg_data_i;
        REG_MEASURE_NOISE: noise_q.r      <= cfg_data_i;
        REG_NUM_SAMPLES:   scale_q.target <= cfg_data_i[CNT_W-1:0];
        REG_AMPS_PER_CNT:  scale_q.apc    <= cfg_data_i;
        REG_CUR_OFFSET:    scale_q.offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencing: both lanes have equal latency and finish in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
    end else begin
      unique case (state_q)
        T_IDLE: if (accept) state_q <= T_BUSY;
        T_BUSY: if (sns_done) state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == T_IDLE) && merge_ready;

  dkdc_lane #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_sns (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .z_i     (sensor_sample_i),
    .noise_i (noise_q),
    .load_i  (load_sns),
    .init_i  (cfg_data_i[CNT_W-1:0]),
    .done_o  (sns_done),
    .est_o   (est_sns)
  );

  dkdc_lane #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_ref (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .z_i     (reference_sample_i),
    .noise_i (noise_q),
    .load_i  (load_ref),
    .init_i  (cfg_data_i[CNT_W-1:0]),
    .done_o  (ref_done),
    .est_o   (est_ref)
  );

  dkdc_merge #(
    .EST_W (EST_W)
  ) u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .add_i             (sns_done && ref_done),
    .est_a_i           (est_sns),
    .est_b_i           (est_ref),
    .scale_i           (scale_q),
    .ready_o           (merge_ready),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .dc_current_o      (dc_current_o),
    .mean_difference_o (mean_difference_o)
  );

endmodule

// File: design/dkdc_checker.sv
// Port-level checker for the dual Kalman differential current block.
module dkdc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [31:0] dc_current_o
);

  // An accepted pair keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken in the cycle after an accepted word");

  // A new result only rises out of a state in which input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while input side was open");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(dc_current_o)))
    else $error("stalled result changed or dropped");

endmodule

bind dual_kalman_differential_current dkdc_checker u_dkdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .dc_current_o (dc_current_o)
);
